/* design/stbs_pkg.sv */
// stbs_pkg: shared types and constants for the sorted table binary search core.
// Used by stbs_ctrl, stbs_dp and sorted_table_binary_search_core.
package stbs_pkg;

    localparam int ENTRY_W    = 8;   // entry_index, search_low, found_index
    localparam int HIGH_W     = 9;   // search_high, signed
    localparam int IN_VALUE_W = 32;  // entry_value, search_key
    localparam int RANGE_W    = 10;  // signed range bounds, -256 .. 256

    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    typedef logic signed [RANGE_W-1:0] t_range;

    // controller -> datapath
    typedef struct packed {
        logic load_wr;   // write one table entry
        logic start;     // latch key and range, issue first probe read
        logic probe;     // compare read word, narrow range
        logic load_out;  // move result into output register
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic start_empty;  // clamped request range is empty
        logic hit;          // current probe matches key
        logic next_empty;   // narrowed range is empty
    } t_dp_sts;

endpackage

/* design/stbs_ctrl.sv */
// stbs_ctrl: search sequencer and output word valid.
// Depends on stbs_pkg; drives stbs_dp through t_dp_cmd.
module stbs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_req_type,
    input  logic              i_out_stall,
    input  stbs_pkg::t_dp_sts i_sts,
    output stbs_pkg::t_dp_cmd o_cmd,
    output logic              o_in_stall,
    output logic              o_out_valid
);
    import stbs_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   in_acc;

    // no word is taken while reset is held
    assign o_in_stall  = (r_state != ST_IDLE) || !i_rst_n;
    assign in_acc      = i_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd.load_wr  = in_acc && (i_req_type == REQ_LOAD);
        o_cmd.start    = in_acc && (i_req_type == REQ_SEARCH);
        o_cmd.probe    = (r_state == ST_PROBE);
        o_cmd.load_out = (r_state == ST_DONE) && (!r_out_valid || !i_out_stall);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (o_cmd.start) begin
                    n_state = i_sts.start_empty ? ST_DONE : ST_PROBE;
                end
            end
            ST_PROBE: begin
                if (i_sts.hit || i_sts.next_empty) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (o_cmd.load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

/* design/stbs_dp.sv */
// stbs_dp: table memory, range registers, probe compare and result registers.
// Depends on stbs_pkg; commanded by stbs_ctrl.
module stbs_dp #(
    parameter int DEPTH       = 256,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                     i_clk,
    input  stbs_pkg::t_dp_cmd                        i_cmd,
    input  logic [stbs_pkg::ENTRY_W-1:0]             i_entry_index,
    input  logic signed [stbs_pkg::IN_VALUE_W-1:0]   i_entry_value,
    input  logic signed [stbs_pkg::IN_VALUE_W-1:0]   i_search_key,
    input  logic [stbs_pkg::ENTRY_W-1:0]             i_search_low,
    input  logic signed [stbs_pkg::HIGH_W-1:0]       i_search_high,
    output stbs_pkg::t_dp_sts                        o_sts,
    output logic                                     o_found,
    output logic [stbs_pkg::ENTRY_W-1:0]             o_found_index
);
    import stbs_pkg::*;

    localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ClampMax = (DEPTH - 1 < 255) ? DEPTH - 1 : 255;
    localparam t_range ClampR = t_range'(ClampMax);

    logic [VALUE_WIDTH-1:0] mem [DEPTH];

    logic [VALUE_WIDTH-1:0] r_key;
    logic [VALUE_WIDTH-1:0] r_rdata;
    t_range                 r_lo, r_hi;
    logic [ENTRY_W-1:0]     r_mid;
    logic                   r_res_found;
    logic [ENTRY_W-1:0]     r_res_idx;
    logic                   r_found;
    logic [ENTRY_W-1:0]     r_found_index;

    logic [63:0]            val_ext, key_ext;
    logic [VALUE_WIDTH-1:0] wr_val, key_val;
    t_range                 lo_c, hi_c, n_lo, n_hi, mid_r;
    logic signed [RANGE_W:0] sum_s, sum_p;
    logic [ENTRY_W-1:0]     mid_s, mid_p, rd_mid;
    logic [AW+ENTRY_W-1:0]  rd_wide, wr_wide;
    logic [AW-1:0]          rd_addr, wr_addr;
    logic                   wr_ok, hit, key_lt;

    // words arrive as 32-bit two's complement, kept at VALUE_WIDTH bits
    assign val_ext = {{(64-IN_VALUE_W){i_entry_value[IN_VALUE_W-1]}}, i_entry_value};
    assign key_ext = {{(64-IN_VALUE_W){i_search_key[IN_VALUE_W-1]}}, i_search_key};
    assign wr_val  = val_ext[VALUE_WIDTH-1:0];
    assign key_val = key_ext[VALUE_WIDTH-1:0];

    // clamp request range to the last table entry
    always_comb begin
        lo_c = $signed({2'b00, i_search_low});
        if (lo_c > ClampR) begin
            lo_c = ClampR;
        end
        hi_c = $signed({i_search_high[HIGH_W-1], i_search_high});
        if (hi_c > ClampR) begin
            hi_c = ClampR;
        end
    end

    // floor midpoint; only used when the range is non-empty, so sum >= 0
    assign sum_s = $signed({lo_c[RANGE_W-1], lo_c}) + $signed({hi_c[RANGE_W-1], hi_c});
    assign mid_s = sum_s[ENTRY_W:1];

    assign mid_r  = $signed({2'b00, r_mid});
    assign hit    = (r_rdata == r_key);
    assign key_lt = ($signed(r_key) < $signed(r_rdata));

    always_comb begin
        if (key_lt) begin
            n_lo = r_lo;
            n_hi = mid_r - t_range'(1);
        end else begin
            n_lo = mid_r + t_range'(1);
            n_hi = r_hi;
        end
    end

    assign sum_p = $signed({n_lo[RANGE_W-1], n_lo}) + $signed({n_hi[RANGE_W-1], n_hi});
    assign mid_p = sum_p[ENTRY_W:1];

    assign o_sts.start_empty = (hi_c < lo_c);
    assign o_sts.hit         = hit;
    assign o_sts.next_empty  = (n_hi < n_lo);

    assign rd_mid  = i_cmd.start ? mid_s : mid_p;
    assign rd_wide = {{AW{1'b0}}, rd_mid};
    assign rd_addr = rd_wide[AW-1:0];
    assign wr_wide = {{AW{1'b0}}, i_entry_index};
    assign wr_addr = wr_wide[AW-1:0];
    assign wr_ok   = ($signed({2'b00, i_entry_index}) <= ClampR);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr && wr_ok) begin
            mem[wr_addr] <= wr_val;
        end
        r_rdata <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_key       <= key_val;
            r_lo        <= lo_c;
            r_hi        <= hi_c;
            r_mid       <= mid_s;
            r_res_found <= 1'b0;
            r_res_idx   <= '0;
        end else if (i_cmd.probe) begin
            r_lo  <= n_lo;
            r_hi  <= n_hi;
            r_mid <= mid_p;
            if (hit) begin
                r_res_found <= 1'b1;
                r_res_idx   <= r_mid;
            end
        end
        if (i_cmd.load_out) begin
            r_found       <= r_res_found;
            r_found_index <= r_res_idx;
        end
    end

    assign o_found       = r_found;
    assign o_found_index = r_found_index;

endmodule

/* design/sorted_table_binary_search_core.sv */
// Sorted table binary search core. A load word writes one table entry and gives no result.
// A search word: a setup step, then one probe per cycle (one memory read each),
// at most floor(log2(range))+1 probes, then a move into the output register, which waits
// while a held result is stalled by i_stall. The next word is taken once the result is registered.
// Reset (synchronous, active low) clears the sequencer and output valid; table
// contents are undefined until loaded.
module sorted_table_binary_search_core #(
    parameter int DEPTH       = 256,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic                                   i_req_type,
    input  logic [stbs_pkg::ENTRY_W-1:0]           i_entry_index,
    input  logic signed [stbs_pkg::IN_VALUE_W-1:0] i_entry_value,
    input  logic signed [stbs_pkg::IN_VALUE_W-1:0] i_search_key,
    input  logic [stbs_pkg::ENTRY_W-1:0]           i_search_low,
    input  logic signed [stbs_pkg::HIGH_W-1:0]     i_search_high,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic                                   o_found,
    output logic [stbs_pkg::ENTRY_W-1:0]           o_found_index
);
    import stbs_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    stbs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_req_type  (i_req_type),
        .i_out_stall (i_stall),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_stall  (o_stall),
        .o_out_valid (o_valid)
    );

    stbs_dp #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_cmd         (cmd),
        .i_entry_index (i_entry_index),
        .i_entry_value (i_entry_value),
        .i_search_key  (i_search_key),
        .i_search_low  (i_search_low),
        .i_search_high (i_search_high),
        .o_sts         (sts),
        .o_found       (o_found),
        .o_found_index (o_found_index)
    );

    // a miss always reports index zero
    a_miss_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_found |-> o_found_index == '0)
        else $error("miss with nonzero index");

    // a load completes in the cycle it is taken
    a_load_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_req_type == REQ_LOAD |=> !o_stall)
        else $error("load held the input");

    // a search always occupies the sequencer
    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_req_type == REQ_SEARCH |=> o_stall)
        else $error("search did not start");

endmodule
